// ===== rtl/pwdf_pkg.sv =====
// Package for the power-weighted dominant frequency block.
// Holds field widths, divider control types and shared constants.
// No dependencies.
package pwdf_pkg;

   localparam int ELEC_W     = 6;
   localparam int BAND_W     = 3;
   localparam int FREQ_W     = 14;
   localparam int AMP_W      = 12;
   localparam int SQ_W       = 2 * AMP_W;
   localparam int PROD_W     = FREQ_W + SQ_W;
   localparam int POWER_W    = 27;
   localparam int WEIGHTED_W = 41;
   localparam int TOTAL_W    = 21;
   localparam int DIV_CNT_W  = 6;

   localparam logic [DIV_CNT_W-1:0] STEPS_DOMINANT = DIV_CNT_W'(WEIGHTED_W);
   localparam logic [DIV_CNT_W-1:0] STEPS_BASELINE = DIV_CNT_W'(TOTAL_W);

   localparam logic OP_CLEAR  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic KIND_ELECTRODE = 1'b0;
   localparam logic KIND_BASELINE  = 1'b1;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
   } div_ctrl_type;

endpackage

// ===== rtl/power_weighted_dominant_frequency.sv =====
// Power-weighted dominant frequency per electrode with an overall baseline.
// A band sample that does not complete an electrode runs the square and accumulate states
// and returns to idle. A completing sample then runs a 41-step divide for its result; a
// baseline follows from the shared divider once that result is taken and all are done.
// Clear and ignored requests stay in idle. Synchronous reset clears control state, sums,
// done mask and result valid; the value store needs no clearing: the done mask gates reads.
module power_weighted_dominant_frequency #(
   parameter int ELECTRODES = 21,
   parameter int BANDS      = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [pwdf_pkg::ELEC_W-1:0]         req_electrode,
   input  logic [pwdf_pkg::BAND_W-1:0]         req_band,
   input  logic [pwdf_pkg::FREQ_W-1:0]         req_band_frequency,
   input  logic [pwdf_pkg::AMP_W-1:0]          req_band_amplitude,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_kind,
   output logic [pwdf_pkg::ELEC_W-1:0]         rsp_source_electrode,
   output logic [pwdf_pkg::FREQ_W-1:0]         rsp_frequency_value,
   output logic                                rsp_zero_power,
   output logic                                rsp_last
);

   localparam int ELEC_AW = (ELECTRODES > 1) ? $clog2(ELECTRODES) : 1;
   localparam logic [pwdf_pkg::ELEC_W:0]       ELEC_LIM  = (pwdf_pkg::ELEC_W+1)'(ELECTRODES);
   localparam logic [pwdf_pkg::BAND_W:0]       BAND_LIM  = (pwdf_pkg::BAND_W+1)'(BANDS);
   localparam logic [pwdf_pkg::BAND_W-1:0]     LAST_BAND = pwdf_pkg::BAND_W'(BANDS - 1);
   localparam logic [pwdf_pkg::POWER_W-1:0]    ELEC_DIV  = pwdf_pkg::POWER_W'(ELECTRODES);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQUARE, ST_ACCUM, ST_DIV_LOAD, ST_DIVIDE,
      ST_UPDATE, ST_EMIT_EL, ST_BASE_DIV, ST_EMIT_BASE
   } state_type;

   state_type                             state_ff, state_in;
   logic [pwdf_pkg::ELEC_W-1:0]           elec_ff, elec_in;
   logic [pwdf_pkg::BAND_W-1:0]           band_ff, band_in;
   logic [pwdf_pkg::FREQ_W-1:0]           freq_ff, freq_in;
   logic [pwdf_pkg::AMP_W-1:0]            amp_ff, amp_in;
   logic [pwdf_pkg::SQ_W-1:0]             sq_ff, sq_in;
   logic [pwdf_pkg::POWER_W-1:0]          power_ff, power_in;
   logic [pwdf_pkg::WEIGHTED_W-1:0]       weighted_ff, weighted_in;
   logic [ELECTRODES-1:0]                 done_ff, done_in;
   logic [pwdf_pkg::TOTAL_W-1:0]          total_ff, total_in;
   logic                                  all_done_ff, all_done_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  rsp_kind_ff, rsp_kind_in;
   logic [pwdf_pkg::ELEC_W-1:0]           rsp_src_ff, rsp_src_in;
   logic [pwdf_pkg::FREQ_W-1:0]           rsp_value_ff, rsp_value_in;
   logic                                  rsp_zp_ff, rsp_zp_in;
   logic                                  rsp_last_ff, rsp_last_in;

   logic [pwdf_pkg::PROD_W-1:0]           prod;
   logic [ELEC_AW-1:0]                    addr;
   logic                                  ram_we;
   logic [pwdf_pkg::FREQ_W-1:0]           ram_wdata;
   logic [pwdf_pkg::FREQ_W-1:0]           ram_rdata;
   pwdf_pkg::div_ctrl_type                div_ctrl;
   logic [pwdf_pkg::WEIGHTED_W-1:0]       div_dividend;
   logic [pwdf_pkg::POWER_W-1:0]          div_divisor;
   logic                                  div_busy;
   logic [pwdf_pkg::WEIGHTED_W-1:0]       div_quot;
   logic                                  zero_pwr;
   logic [pwdf_pkg::FREQ_W-1:0]           value;
   logic [pwdf_pkg::FREQ_W-1:0]           old_value;
   logic                                  in_range;

   assign prod      = freq_ff * sq_ff;
   assign addr      = elec_ff[ELEC_AW-1:0];
   assign zero_pwr  = (power_ff == '0);
   assign value     = zero_pwr ? '0 : div_quot[pwdf_pkg::FREQ_W-1:0];
   assign old_value = done_ff[addr] ? ram_rdata : '0;
   assign in_range  = ({1'b0, req_electrode} < ELEC_LIM) && ({1'b0, req_band} < BAND_LIM);

   always_comb begin
      state_in     = state_ff;
      elec_in      = elec_ff;
      band_in      = band_ff;
      freq_in      = freq_ff;
      amp_in       = amp_ff;
      sq_in        = sq_ff;
      power_in     = power_ff;
      weighted_in  = weighted_ff;
      done_in      = done_ff;
      total_in     = total_ff;
      all_done_in  = all_done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_value_in = rsp_value_ff;
      rsp_zp_in    = rsp_zp_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_wdata    = value;
      div_ctrl     = '0;
      div_dividend = weighted_ff;
      div_divisor  = power_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               elec_in = req_electrode;
               band_in = req_band;
               freq_in = req_band_frequency;
               amp_in  = req_band_amplitude;
               if (req_opcode == pwdf_pkg::OP_CLEAR) begin
                  power_in    = '0;
                  weighted_in = '0;
                  done_in     = '0;
                  total_in    = '0;
               end else if (in_range) begin
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            sq_in    = amp_ff * amp_ff;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            power_in = ((band_ff == '0) ? '0 : power_ff)
                     + {{(pwdf_pkg::POWER_W - pwdf_pkg::SQ_W){1'b0}}, sq_ff};
            weighted_in = ((band_ff == '0) ? '0 : weighted_ff)
                        + {{(pwdf_pkg::WEIGHTED_W - pwdf_pkg::PROD_W){1'b0}}, prod};
            state_in = (band_ff == LAST_BAND) ? ST_DIV_LOAD : ST_IDLE;
         end
         ST_DIV_LOAD: begin
            div_ctrl.start = 1'b1;
            div_ctrl.steps = pwdf_pkg::STEPS_DOMINANT;
            state_in       = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!div_busy) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ram_we        = 1'b1;
            done_in       = done_ff;
            done_in[addr] = 1'b1;
            all_done_in   = &done_in;
            total_in      = total_ff
                          - {{(pwdf_pkg::TOTAL_W - pwdf_pkg::FREQ_W){1'b0}}, old_value}
                          + {{(pwdf_pkg::TOTAL_W - pwdf_pkg::FREQ_W){1'b0}}, value};
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = pwdf_pkg::KIND_ELECTRODE;
            rsp_src_in    = elec_ff;
            rsp_value_in  = value;
            rsp_zp_in     = zero_pwr;
            rsp_last_in   = ~all_done_in;
            state_in      = ST_EMIT_EL;
         end
         ST_EMIT_EL: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (all_done_ff) begin
                  div_ctrl.start = 1'b1;
                  div_ctrl.steps = pwdf_pkg::STEPS_BASELINE;
                  div_dividend   = {total_ff,
                                    {(pwdf_pkg::WEIGHTED_W - pwdf_pkg::TOTAL_W){1'b0}}};
                  div_divisor    = ELEC_DIV;
                  state_in       = ST_BASE_DIV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BASE_DIV: begin
            if (!div_busy) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pwdf_pkg::KIND_BASELINE;
               rsp_src_in   = '0;
               rsp_value_in = div_quot[pwdf_pkg::FREQ_W-1:0];
               rsp_zp_in    = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_EMIT_BASE;
            end
         end
         ST_EMIT_BASE: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         power_ff     <= '0;
         weighted_ff  <= '0;
         done_ff      <= '0;
         total_ff     <= '0;
         all_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         power_ff     <= power_in;
         weighted_ff  <= weighted_in;
         done_ff      <= done_in;
         total_ff     <= total_in;
         all_done_ff  <= all_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      elec_ff      <= elec_in;
      band_ff      <= band_in;
      freq_ff      <= freq_in;
      amp_ff       <= amp_in;
      sq_ff        <= sq_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_src_ff   <= rsp_src_in;
      rsp_value_ff <= rsp_value_in;
      rsp_zp_ff    <= rsp_zp_in;
      rsp_last_ff  <= rsp_last_in;
   end

   pwdf_ram #(
      .WIDTH (pwdf_pkg::FREQ_W),
      .DEPTH (ELECTRODES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr),
      .wr_data (ram_wdata),
      .rd_addr (addr),
      .rd_data (ram_rdata)
   );

   pwdf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_source_electrode = rsp_src_ff;
   assign rsp_frequency_value  = rsp_value_ff;
   assign rsp_zero_power       = rsp_zp_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

// ===== rtl/pwdf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Parameters set width and depth. No dependencies.
module pwdf_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 21
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pwdf_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// The number of steps is chosen at start; the dividend is taken MSB first.
// Depends on pwdf_pkg.
module pwdf_div (
   input  logic                                clock,
   input  logic                                reset,
   input  pwdf_pkg::div_ctrl_type              ctrl,
   input  logic [pwdf_pkg::WEIGHTED_W-1:0]     dividend,
   input  logic [pwdf_pkg::POWER_W-1:0]        divisor,
   output logic                                busy,
   output logic [pwdf_pkg::WEIGHTED_W-1:0]     quotient
);

   logic                                busy_ff;
   logic [pwdf_pkg::DIV_CNT_W-1:0]      cnt_ff;
   logic [pwdf_pkg::WEIGHTED_W-1:0]     num_ff;
   logic [pwdf_pkg::POWER_W-1:0]        den_ff;
   logic [pwdf_pkg::POWER_W-1:0]        rem_ff;
   logic [pwdf_pkg::WEIGHTED_W-1:0]     quot_ff;
   logic [pwdf_pkg::POWER_W:0]          shifted;
   logic [pwdf_pkg::POWER_W+1:0]        diff;
   logic                                fits;

   assign shifted = {rem_ff, num_ff[pwdf_pkg::WEIGHTED_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = ~diff[pwdf_pkg::POWER_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (ctrl.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= ctrl.steps;
         num_ff  <= dividend;
         den_ff  <= divisor;
         rem_ff  <= '0;
         quot_ff <= '0;
      end else if (busy_ff) begin
         num_ff  <= {num_ff[pwdf_pkg::WEIGHTED_W-2:0], 1'b0};
         rem_ff  <= fits ? diff[pwdf_pkg::POWER_W-1:0] : shifted[pwdf_pkg::POWER_W-1:0];
         quot_ff <= {quot_ff[pwdf_pkg::WEIGHTED_W-2:0], fits};
         cnt_ff  <= cnt_ff - 1'b1;
         if (cnt_ff == pwdf_pkg::DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

// ===== rtl/pwdf_checker.sv =====
// Port-level checker for the power-weighted dominant frequency block.
// Bound to the top level below. Depends on pwdf_pkg.
module pwdf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_kind,
   input logic [pwdf_pkg::ELEC_W-1:0]         rsp_source_electrode,
   input logic [pwdf_pkg::FREQ_W-1:0]         rsp_frequency_value,
   input logic                                rsp_zero_power,
   input logic                                rsp_last
);

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_source_electrode) && $stable(rsp_frequency_value)
         && $stable(rsp_zero_power) && $stable(rsp_last))
      else $error("result payload changed while stalled");

   // No new request transaction is taken while a result is pending.
   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a result is pending");

   // The baseline is always the final result, with no electrode and no zero flag.
   a_baseline_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == pwdf_pkg::KIND_BASELINE) |->
         rsp_last && !rsp_zero_power && (rsp_source_electrode == '0))
      else $error("malformed baseline result");

   // A zero-power result carries a zero frequency.
   a_zero_power: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_power |-> (rsp_frequency_value == '0))
      else $error("zero power result with nonzero frequency");

endmodule

bind power_weighted_dominant_frequency pwdf_checker u_pwdf_checker (.*);

// ===== dv/tb_power_weighted_dominant_frequency.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for power_weighted_dominant_frequency, with a queue-fed driver,
// a checking monitor and a predictor of per-electrode and baseline frequencies.
// Depends on pwdf_pkg and the RTL top level.
module tb_power_weighted_dominant_frequency;

   localparam int ELECTRODE_COUNT = 21;
   localparam int NUM_BANDS      = 4;
   localparam int RANDOM_ITEMS   = 400;
   localparam int HOLD_AFTER     = 150;
   localparam int HOLD_CYCLES    = 500;
   localparam int DRAIN_CYCLES   = 120;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int FREQ_MAX       = (1 << pwdf_pkg::FREQ_W) - 1;
   localparam int AMP_MAX        = (1 << pwdf_pkg::AMP_W) - 1;

   typedef struct packed {
      logic                        opcode;
      logic [pwdf_pkg::ELEC_W-1:0] electrode;
      logic [pwdf_pkg::BAND_W-1:0] band;
      logic [pwdf_pkg::FREQ_W-1:0] band_frequency;
      logic [pwdf_pkg::AMP_W-1:0]  band_amplitude;
   } sample_type;

   typedef struct packed {
      logic                        kind;
      logic [pwdf_pkg::ELEC_W-1:0] source_electrode;
      logic [pwdf_pkg::FREQ_W-1:0] frequency_value;
      logic                        zero_power;
      logic                        last;
   } freq_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_opcode = pwdf_pkg::OP_CLEAR;
   logic [pwdf_pkg::ELEC_W-1:0] req_electrode = '0;
   logic [pwdf_pkg::BAND_W-1:0] req_band = '0;
   logic [pwdf_pkg::FREQ_W-1:0] req_band_frequency = '0;
   logic [pwdf_pkg::AMP_W-1:0]  req_band_amplitude = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_kind;
   logic [pwdf_pkg::ELEC_W-1:0] rsp_source_electrode;
   logic [pwdf_pkg::FREQ_W-1:0] rsp_frequency_value;
   logic                        rsp_zero_power;
   logic                        rsp_last;

   sample_type      band_samples[$];
   freq_result_type due_frequencies[$];
   sample_type      staged;
   sample_type      on_offer;
   logic            have_staged = 1'b0;
   int              gap_left = 0;
   int              pause_left = 0;
   int              hold_left = 0;
   logic            held = 1'b0;
   logic            no_idle = 1'b0;
   int              samples_sent = 0;
   int              samples_total = 0;
   int              live_items = 0;
   int              cycle_count = 0;
   int              errors = 0;

   logic [pwdf_pkg::POWER_W-1:0]    pw_power;
   logic [pwdf_pkg::WEIGHTED_W-1:0] pw_weighted;
   logic [pwdf_pkg::FREQ_W-1:0]     pw_store[ELECTRODE_COUNT];
   logic [ELECTRODE_COUNT-1:0]      pw_done;
   logic [pwdf_pkg::TOTAL_W-1:0]    pw_total;

   power_weighted_dominant_frequency #(
      .ELECTRODES(ELECTRODE_COUNT),
      .BANDS     (NUM_BANDS)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_electrode       (req_electrode),
      .req_band            (req_band),
      .req_band_frequency  (req_band_frequency),
      .req_band_amplitude  (req_band_amplitude),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_source_electrode(rsp_source_electrode),
      .rsp_frequency_value (rsp_frequency_value),
      .rsp_zero_power      (rsp_zero_power),
      .rsp_last            (rsp_last)
   );

   function automatic void clear_frequency_state();
      pw_power = '0;
      pw_weighted = '0;
      pw_done = '0;
      pw_total = '0;
      for (int i = 0; i < ELECTRODE_COUNT; i++) pw_store[i] = '0;
   endfunction

   function automatic void accumulate_band(input sample_type s);
      logic [pwdf_pkg::SQ_W-1:0]   sq;
      logic [pwdf_pkg::FREQ_W-1:0] value;
      logic                        zp;
      freq_result_type             r;
      if (s.opcode == pwdf_pkg::OP_CLEAR) begin
         clear_frequency_state();
         return;
      end
      if (s.electrode >= ELECTRODE_COUNT || s.band >= NUM_BANDS) return;
      sq = s.band_amplitude * s.band_amplitude;
      if (s.band == 0) begin
         pw_power = '0;
         pw_weighted = '0;
      end
      pw_power = pw_power + pwdf_pkg::POWER_W'(sq);
      pw_weighted = pw_weighted
                  + pwdf_pkg::WEIGHTED_W'(s.band_frequency) * pwdf_pkg::WEIGHTED_W'(sq);
      if (s.band != NUM_BANDS - 1) return;
      if (pw_power == '0) begin
         value = '0;
         zp = 1'b1;
      end else begin
         value = pwdf_pkg::FREQ_W'(64'(pw_weighted) / 64'(pw_power));
         zp = 1'b0;
      end
      if (pw_done[s.electrode]) begin
         pw_total = pw_total - pwdf_pkg::TOTAL_W'(pw_store[s.electrode]);
      end
      pw_store[s.electrode] = value;
      pw_total = pw_total + pwdf_pkg::TOTAL_W'(value);
      pw_done[s.electrode] = 1'b1;
      r.kind = pwdf_pkg::KIND_ELECTRODE;
      r.source_electrode = s.electrode;
      r.frequency_value = value;
      r.zero_power = zp;
      r.last = (pw_done != '1);
      due_frequencies = {due_frequencies, r};
      if (pw_done == '1) begin
         r.kind = pwdf_pkg::KIND_BASELINE;
         r.source_electrode = '0;
         r.frequency_value = pwdf_pkg::FREQ_W'(pw_total / ELECTRODE_COUNT);
         r.zero_power = 1'b0;
         r.last = 1'b1;
         due_frequencies = {due_frequencies, r};
      end
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   task automatic push_sample(input logic op, input int elec, input int band, input int freq,
                              input int amp);
      sample_type s;
      s.opcode = op;
      s.electrode = pwdf_pkg::ELEC_W'(elec);
      s.band = pwdf_pkg::BAND_W'(band);
      s.band_frequency = pwdf_pkg::FREQ_W'(freq);
      s.band_amplitude = pwdf_pkg::AMP_W'(amp);
      band_samples = {band_samples, s};
      if (op == pwdf_pkg::OP_CLEAR || (elec < ELECTRODE_COUNT && band < NUM_BANDS)) begin
         live_items++;
      end
   endtask

   task automatic push_measurement(input int elec, input int first_band, input logic silent);
      int amp;
      for (int b = first_band; b < NUM_BANDS; b++) begin
         amp = (silent || $urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, AMP_MAX);
         push_sample(pwdf_pkg::OP_SAMPLE, elec, b, $urandom_range(0, FREQ_MAX), amp);
      end
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 600 == 599) no_idle <= ($urandom_range(0, 2) == 0);
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         have_staged = 1'b0;
         gap_left = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            accumulate_band(on_offer);
            samples_sent <= samples_sent + 1;
         end
         if (!have_staged && band_samples.size() > 0) begin
            staged = band_samples.pop_front();
            have_staged = 1'b1;
            gap_left = no_idle ? 0 : $urandom_range(0, 10);
         end
         if (have_staged && gap_left == 0) begin
            on_offer = staged;
            have_staged = 1'b0;
            req_valid <= 1'b1;
            req_opcode <= staged.opcode;
            req_electrode <= staged.electrode;
            req_band <= staged.band;
            req_band_frequency <= staged.band_frequency;
            req_band_amplitude <= staged.band_amplitude;
         end else begin
            req_valid <= 1'b0;
            if (have_staged) gap_left--;
         end
      end
   end

   // The receiver is held off once for a long stretch so that the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         held <= 1'b0;
      end else if (!held && samples_sent == HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         held <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      freq_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         pause_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_frequencies.size() == 0) begin
               $error("unexpected transaction: kind %0d electrode %0d value %0d",
                      rsp_kind, rsp_source_electrode, rsp_frequency_value);
               errors++;
            end else begin
               want = due_frequencies.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("source_electrode", want.source_electrode, rsp_source_electrode);
               check_field("frequency_value", want.frequency_value, rsp_frequency_value);
               check_field("zero_power", want.zero_power, rsp_zero_power);
               check_field("last", want.last, rsp_last);
            end
            pause_left = no_idle ? 0 : $urandom_range(0, 10);
         end else if (pause_left > 0) begin
            pause_left--;
         end
         rsp_stall <= (hold_left > 0) || (pause_left > 0);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int pick;
      int elec;
      int sweep;
      int target;
      sweep = 0;
      clear_frequency_state();

      push_sample(pwdf_pkg::OP_CLEAR, 63, 7, FREQ_MAX, AMP_MAX);
      push_sample(pwdf_pkg::OP_SAMPLE, 63, 3, FREQ_MAX, AMP_MAX);
      push_sample(pwdf_pkg::OP_SAMPLE, ELECTRODE_COUNT, NUM_BANDS - 1, 100, 100);
      push_sample(pwdf_pkg::OP_SAMPLE, 0, 7, 100, 100);
      push_sample(pwdf_pkg::OP_SAMPLE, 0, NUM_BANDS, 100, 100);
      for (int b = 0; b < NUM_BANDS; b++) begin
         push_sample(pwdf_pkg::OP_SAMPLE, 0, b, FREQ_MAX, AMP_MAX);
      end
      for (int b = 0; b < NUM_BANDS; b++) begin
         push_sample(pwdf_pkg::OP_SAMPLE, ELECTRODE_COUNT - 1, b, FREQ_MAX, 0);
      end
      for (int b = 0; b < NUM_BANDS; b++) begin
         push_sample(pwdf_pkg::OP_SAMPLE, 1, b, 0, AMP_MAX);
      end
      push_sample(pwdf_pkg::OP_SAMPLE, 2, NUM_BANDS - 1, 5000, 1000);
      for (int b = 0; b < NUM_BANDS; b++) begin
         push_sample(pwdf_pkg::OP_SAMPLE, 0, b, b * 4000 + 123, b * 1000 + 1);
      end
      push_sample(pwdf_pkg::OP_CLEAR, 0, 0, 0, 0);

      target = live_items + RANDOM_ITEMS;
      while (live_items < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 1) begin
            push_sample(pwdf_pkg::OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 7),
                        $urandom_range(0, FREQ_MAX), $urandom_range(0, AMP_MAX));
         end else if (pick < 8) begin
            push_sample(pwdf_pkg::OP_SAMPLE, $urandom_range(0, 63), $urandom_range(0, 7),
                        $urandom_range(0, FREQ_MAX), $urandom_range(0, AMP_MAX));
         end else if (pick < 15) begin
            push_measurement($urandom_range(0, ELECTRODE_COUNT - 1),
                             $urandom_range(1, NUM_BANDS - 1), 1'b0);
         end else begin
            if ($urandom_range(0, 9) < 7) begin
               elec = sweep;
               sweep = (sweep + 1) % ELECTRODE_COUNT;
            end else begin
               elec = $urandom_range(0, ELECTRODE_COUNT - 1);
            end
            push_measurement(elec, 0, $urandom_range(0, 19) == 0);
         end
      end
      samples_total = band_samples.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (samples_sent < samples_total) @(posedge clock);
      while (due_frequencies.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
